[src/qcpid_pkg.sv]
// Package for the cascaded PID and X-frame mixer: widths, fixed-point constants, helpers.
package qcpid_pkg;

  localparam int FRAC_BITS = 16;
  // Width of the accumulator and the multiplier's wide operand
  localparam int AW = 40;
  // Width of the multiplier's coefficient operand
  localparam int CW = FRAC_BITS + 1;
  localparam int PW = AW + CW;

  localparam longint ONE = longint'(1) << FRAC_BITS;

  localparam logic signed [AW-1:0] C_DT       = AW'((ONE * 2 * 2 + 100) / 200);
  localparam logic signed [AW-1:0] C_EPS      = AW'((ONE * 2 + 100000) / 200000);
  localparam logic signed [AW-1:0] C_MILLI    = AW'((ONE * 2 + 1000) / 2000);
  localparam logic signed [AW-1:0] C_WIND     = AW'((ONE * 3 * 2 + 10) / 20);
  localparam logic signed [AW-1:0] C_POS_KP   = AW'((ONE * 2 * 2 + 10) / 20);
  localparam logic signed [AW-1:0] C_POS_KD   = AW'((ONE * 2 + 100) / 200);
  localparam logic signed [AW-1:0] C_ATT_KP   = AW'((ONE * 5 * 2 + 100) / 200);
  localparam logic signed [AW-1:0] C_ATT_KI   = AW'((ONE * 2 * 2 + 1000) / 2000);
  localparam logic signed [AW-1:0] C_ATT_KD   = AW'((ONE * 2 + 1000) / 2000);
  localparam logic signed [AW-1:0] C_SET_LIM  = AW'((ONE * 2 + 2) / 4);
  localparam logic signed [AW-1:0] C_RP_LIM   = AW'((ONE * 3 * 2 + 10) / 20);
  localparam logic signed [AW-1:0] C_YAW_LIM  = AW'((ONE * 2 * 2 + 10) / 20);
  localparam logic signed [AW-1:0] C_HSTEP    = AW'((ONE * 2 + 100) / 200);
  localparam logic signed [AW-1:0] C_THR_STEP = AW'((ONE * 2 + 1000) / 2000);
  localparam logic signed [AW-1:0] C_ALT_MARG = AW'(ONE * 15);
  localparam logic signed [AW-1:0] C_THR_MAX  = AW'((ONE * 2 + 2) / 4);
  localparam logic signed [AW-1:0] C_THR_RST  = AW'((ONE * 45 * 2 + 100) / 200);
  localparam logic signed [AW-1:0] C_PWM_SCL  = AW'(1000);
  localparam logic signed [AW-1:0] C_I32_MIN  = AW'(-64'sd2147483648);
  localparam logic signed [AW-1:0] C_I32_MAX  = AW'(64'sd2147483647);
  localparam logic signed [PW-1:0] HALF_P     = PW'(longint'(1) << (FRAC_BITS - 1));

  localparam logic [10:0] PWM_MIN = 11'd1000;
  localparam logic [10:0] PWM_MAX = 11'd2000;

  // Mode codes
  localparam logic [1:0] MODE_STAB = 2'd0;
  localparam logic [1:0] MODE_FLY  = 2'd1;

  // Register indexes
  localparam logic [1:0] REG_MODE    = 2'd0;
  localparam logic [1:0] REG_TGT_X   = 2'd1;
  localparam logic [1:0] REG_TGT_Y   = 2'd2;
  localparam logic [1:0] REG_DESCENT = 2'd3;

  // PID slots
  localparam logic [2:0] PID_X     = 3'd0;
  localparam logic [2:0] PID_Y     = 3'd1;
  localparam logic [2:0] PID_ROLL  = 3'd2;
  localparam logic [2:0] PID_PITCH = 3'd3;
  localparam logic [2:0] PID_YAW   = 3'd4;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_ERR  = 10'b0000000010,
    S_DER  = 10'b0000000100,
    S_INT  = 10'b0000001000,
    S_AP   = 10'b0000010000,
    S_AD   = 10'b0000100000,
    S_AI   = 10'b0001000000,
    S_THR  = 10'b0010000000,
    S_MIX  = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_e;

  // Divide by 2^FRAC_BITS, rounding half away from zero
  function automatic logic signed [AW-1:0] rsh(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] neg_v;
    logic signed [PW-1:0] t;
    neg_v = p[PW-1] ? PW'(1) : '0;
    t = p + HALF_P - neg_v;
    return AW'(t >>> FRAC_BITS);
  endfunction

  function automatic logic signed [AW-1:0] clampq(input logic signed [AW-1:0] v,
                                                  input logic signed [AW-1:0] lo,
                                                  input logic signed [AW-1:0] hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

endpackage

[src/quadcopter_cascaded_pid_mixer_top.sv]
// Cascaded position/attitude PID controller with X-frame motor mixer, one shared multiplier.
// One item (roll, pitch, yaw, x, y) yields one item of four saturated motor pulse widths.
// A small sequencer runs each PID in steps on a single registered multiplier: error,
// derivative, integral, then the P, D and I products summed. Stabilize mode runs the three
// attitude PIDs; other modes run all five plus a thrust update. The mixer then
// scales each of the four motor terms, and the input is not ready again until the result
// item is taken. Configuration must be written while idle through cfg_we_i / cfg_idx_i /
// cfg_wdata_i; the block itself does not enforce this.
module quadcopter_cascaded_pid_mixer_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // roll_angle[18:0], pitch_angle[37:19], yaw_angle[56:38], pos_x[88:57], pos_y[120:89]
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // m1_pulse[10:0], m2_pulse[21:11], m3_pulse[32:22], m4_pulse[43:33]
  output logic [47:0]  m_axis_tdata
);
  import qcpid_pkg::*;

  state_e state_q, state_d;
  logic [1:0]               mode_q;
  logic signed [31:0]       tx_q, ty_q, dr_q;
  logic signed [18:0]       roll_q, pitch_q, yaw_q;
  logic signed [31:0]       posx_q, posy_q;
  logic signed [31:0]       integ_mem [5];
  logic signed [31:0]       last_mem [5];
  logic signed [31:0]       thrust_q, lasth_q;
  logic [2:0]               k_q;
  logic [1:0]               mix_q;
  logic                     mix_tail_q;
  logic signed [31:0]       err_q, integ_q;
  logic signed [AW-1:0]     der_q, acc_q;
  logic signed [PW-1:0]     prod_q;
  logic signed [31:0]       rs_q, ps_q;
  logic signed [AW-1:0]     r_q, p_q, y_q;
  logic [10:0]              pwm_q [4];

  logic                     stab;
  logic signed [AW-1:0]     meas, meas_fix, setp, err_c, der_c, rsh_c, int_c, fin;
  logic signed [AW-1:0]     mul_a, m_sel, thr_ext, dlt, tgt_lim;
  logic signed [CW-1:0]     mul_b, kp, ki, kd;
  logic signed [AW-1:0]     d_h, step, new_thr;
  logic                     low, big, flying;
  logic [10:0]              pwm_c;

  assign stab = (mode_q == MODE_STAB);
  assign flying = (mode_q == MODE_FLY);
  assign rsh_c = rsh(prod_q);
  assign thr_ext = AW'(thrust_q);

  // Select the PID operands of the current slot
  always_comb begin
    case (k_q)
      PID_X:     begin meas = AW'(posx_q); setp = AW'(tx_q); end
      PID_Y:     begin meas = AW'(posy_q); setp = AW'(ty_q); end
      PID_ROLL:  begin meas = AW'(roll_q); setp = stab ? '0 : AW'(rs_q); end
      PID_PITCH: begin meas = AW'(pitch_q); setp = stab ? '0 : AW'(ps_q); end
      default:   begin meas = AW'(yaw_q); setp = '0; end
    endcase
    if (k_q == PID_X || k_q == PID_Y) begin
      kp = CW'(C_POS_KP); ki = '0; kd = CW'(C_POS_KD);
    end else begin
      kp = CW'(C_ATT_KP); ki = CW'(C_ATT_KI); kd = CW'(C_ATT_KD);
    end
    meas_fix = (meas < C_EPS) ? C_MILLI : meas;
    err_c = clampq(setp - meas_fix, C_I32_MIN, C_I32_MAX);
    dlt = AW'(err_q) - AW'(last_mem[k_q]);
    der_c = (dlt <<< 5) + (dlt <<< 4) + (dlt <<< 1);
    int_c = clampq(AW'(integ_mem[k_q]) + rsh_c, -C_WIND, C_WIND);
    fin = acc_q + rsh_c;
  end

  // Mixer term for the current motor
  always_comb begin
    case (mix_q)
      2'd0:    m_sel = thr_ext - r_q + p_q + y_q;
      2'd1:    m_sel = thr_ext + r_q - p_q + y_q;
      2'd2:    m_sel = thr_ext + r_q + p_q - y_q;
      default: m_sel = thr_ext - r_q - p_q - y_q;
    endcase
    if (rsh_c < 0) pwm_c = PWM_MIN;
    else if (rsh_c > C_PWM_SCL) pwm_c = PWM_MAX;
    else pwm_c = PWM_MIN + rsh_c[10:0];
  end

  // Thrust step from the change of height
  always_comb begin
    d_h = AW'(lasth_q) - AW'(posy_q);
    tgt_lim = AW'(ty_q) + C_ALT_MARG;
    low = AW'(posy_q) < tgt_lim;
    big = (d_h >= C_HSTEP) || (d_h <= -C_HSTEP);
    step = '0;
    if (big) begin
      if (d_h >= 0) step = (low && flying) ? C_THR_STEP : -C_THR_STEP;
      else if (dr_q < 0) step = (!low && flying) ? C_THR_STEP : -C_THR_STEP;
      else if (dr_q > 0) step = C_THR_STEP;
    end
    new_thr = clampq(thr_ext + step, '0, C_THR_MAX);
  end

  // Route the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_DER:   begin mul_a = AW'(err_q); mul_b = CW'(C_DT); end
      S_INT:   begin mul_a = AW'(err_q); mul_b = kp; end
      S_AP:    begin mul_a = der_q; mul_b = kd; end
      S_AD:    begin mul_a = AW'(integ_q); mul_b = ki; end
      S_MIX:   begin mul_a = m_sel; mul_b = CW'(C_PWM_SCL); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Sequence the steps
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (s_axis_tvalid) state_d = S_ERR;
      S_ERR:  state_d = S_DER;
      S_DER:  state_d = S_INT;
      S_INT:  state_d = S_AP;
      S_AP:   state_d = S_AD;
      S_AD:   state_d = S_AI;
      S_AI: begin
        if (k_q != PID_YAW) state_d = S_ERR;
        else if (stab) state_d = S_MIX;
        else state_d = S_THR;
      end
      S_THR:  state_d = S_MIX;
      S_MIX:  if (mix_tail_q) state_d = S_OUT;
      S_OUT:  if (m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q <= MODE_FLY;
      tx_q <= '0;
      ty_q <= '0;
      dr_q <= '0;
      for (int i = 0; i < 5; i++) begin
        integ_mem[i] <= '0;
        last_mem[i] <= '0;
      end
      thrust_q <= 32'(C_THR_RST);
      lasth_q <= '0;
      k_q <= '0;
      mix_q <= '0;
      mix_tail_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // Hold register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MODE:    mode_q <= cfg_wdata_i[1:0];
          REG_TGT_X:   tx_q <= cfg_wdata_i;
          REG_TGT_Y:   ty_q <= cfg_wdata_i;
          REG_DESCENT: dr_q <= cfg_wdata_i;
          default:     mode_q <= mode_q;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          k_q <= stab ? PID_ROLL : PID_X;
          mix_q <= '0;
          mix_tail_q <= 1'b0;
        end
        S_DER: last_mem[k_q] <= err_q;
        S_INT: integ_mem[k_q] <= 32'(int_c);
        S_AI:  if (k_q != PID_YAW) k_q <= k_q + 3'd1;
        S_THR: begin
          lasth_q <= posy_q;
          thrust_q <= 32'(new_thr);
        end
        S_MIX: begin
          mix_q <= mix_q + 2'd1;
          if (mix_q == 2'd3) mix_tail_q <= 1'b1;
        end
        default: k_q <= k_q;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (state_q == S_IDLE && s_axis_tvalid) begin
      roll_q  <= s_axis_tdata[18:0];
      pitch_q <= s_axis_tdata[37:19];
      yaw_q   <= s_axis_tdata[56:38];
      posx_q  <= s_axis_tdata[88:57];
      posy_q  <= s_axis_tdata[120:89];
    end
    case (state_q)
      S_ERR: err_q <= 32'(err_c);
      S_DER: der_q <= der_c;
      S_INT: integ_q <= 32'(int_c);
      S_AP:  acc_q <= rsh_c;
      S_AD:  acc_q <= fin;
      S_AI: begin
        case (k_q)
          PID_X:     rs_q <= 32'(clampq(fin, -C_SET_LIM, C_SET_LIM));
          PID_Y:     ps_q <= 32'(clampq(-fin, -C_SET_LIM, C_SET_LIM));
          PID_ROLL:  r_q <= stab ? fin : clampq(fin, -C_RP_LIM, C_RP_LIM);
          PID_PITCH: p_q <= stab ? fin : clampq(fin, -C_RP_LIM, C_RP_LIM);
          default:   y_q <= stab ? fin : clampq(fin, -C_YAW_LIM, C_YAW_LIM);
        endcase
      end
      S_MIX: if (mix_q != 2'd0 || mix_tail_q) pwm_q[mix_q - 2'd1] <= pwm_c;
      default: acc_q <= acc_q;
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {4'd0, pwm_q[3], pwm_q[2], pwm_q[1], pwm_q[0]};

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is pending");

  a_pwm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[10:0] >= PWM_MIN && m_axis_tdata[10:0] <= PWM_MAX &&
                       m_axis_tdata[43:33] >= PWM_MIN && m_axis_tdata[43:33] <= PWM_MAX))
    else $error("motor pulse width out of range");

  a_thrust_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_THR) |=> (thrust_q >= 0 && AW'(thrust_q) <= C_THR_MAX))
    else $error("base thrust left its range");

endmodule
